@@ rtl/sensor_health_monitor_defines.svh @@
// ----------------------------------------------------------------------------
// sensor health monitor assertion macros
// shared property shorthands, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef SENSOR_HEALTH_MONITOR_DEFINES_SVH
`define SENSOR_HEALTH_MONITOR_DEFINES_SVH

// same-cycle implication
`define SHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shm_pkg.sv @@
// ----------------------------------------------------------------------------
// shm_pkg
// shared widths, codes and constants of the sensor health monitor
// ----------------------------------------------------------------------------
package shm_pkg;

  // window
  localparam int DEFAULT_WINDOW_DEPTH = 16;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int HEALTH_W   = 3;
  localparam int CONF_W     = 15;
  localparam int MARGIN_W   = 15;
  localparam int TOL_W      = 16;
  localparam int THRESH_W   = 31;
  localparam int VAR_W      = 31;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_MARGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSTABLE_THR = 3'd4;

  // register reset values
  localparam logic signed [SAMPLE_W-1:0] RST_MIN_VALID = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX_VALID = 16'sd4096;
  localparam logic [MARGIN_W-1:0]        RST_DISC_MARGIN = 15'd20;
  localparam logic [TOL_W-1:0]           RST_STUCK_TOL = 16'd4;
  localparam logic [THRESH_W-1:0]        RST_UNSTABLE_THR = 31'd16777;

  // health codes
  localparam logic [HEALTH_W-1:0] HEALTH_OK           = 3'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_INVALID      = 3'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_DISCONNECTED = 3'd2;
  localparam logic [HEALTH_W-1:0] HEALTH_STUCK        = 3'd3;
  localparam logic [HEALTH_W-1:0] HEALTH_UNSTABLE     = 3'd4;

  // confidence levels, 1/256 percent
  localparam logic [CONF_W-1:0] FULL_CONF  = 15'd25600;
  localparam logic [CONF_W-1:0] STUCK_CONF = 15'd2560;
  localparam logic [CONF_W-1:0] ZERO_CONF  = 15'd0;

  // variance to confidence scaling: drop = (var * FULL_CONF) >> VAR_FRAC
  localparam int VAR_FRAC = 24;
  localparam int PROD_W   = VAR_W + CONF_W;

endpackage

@@ rtl/shm_divider.sv @@
// ----------------------------------------------------------------------------
// shm_divider
// variance divide by the squared window depth, a power of two, as one
// registered shift
// ----------------------------------------------------------------------------
module shm_divider #(
  parameter int NUM_W = 40,
  parameter int SHIFT = 8,
  parameter int QUO_W = shm_pkg::VAR_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  // control: quotient ready in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // datapath: shift the numerator down
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= QUO_W'(num >> SHIFT);
    end
  end

endmodule

@@ rtl/sensor_health_monitor.sv @@
// result path: out of range, near a bound or still filling goes straight to the done
//   state; stuck leaves after the square state; else divide, scale and clamp follow
// throughput: one sample in flight; the next beat is taken once the result is
//   handed to the output register, which holds it until the sink takes it
// reset: synchronous rst clears control, fill count and ring pointer, loads register
//   defaults; no clearing pass, the ring is read only once full
// ----------------------------------------------------------------------------
// sensor_health_monitor
// rates each sensor sample from range checks and the statistics of a window
// ----------------------------------------------------------------------------
module sensor_health_monitor #(
  // window depth, a power of two
  parameter int WINDOW_DEPTH = shm_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [shm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shm_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [shm_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [shm_pkg::M_TDATA_W-1:0] m_tdata    // [2:0] health, [17:3] confidence
);

  import shm_pkg::*;

  `include "sensor_health_monitor_defines.svh"

  localparam int N     = WINDOW_DEPTH;
  localparam int AW    = $clog2(N);
  localparam int CNT_W = $clog2(N + 1);
  localparam int S1_W  = SAMPLE_W + AW;
  localparam int S2_W  = 2 * SAMPLE_W - 1 + AW;
  localparam int NUM_W = 2 * S1_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_CLAMP  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state;

  // configuration registers
  logic signed [SAMPLE_W-1:0] min_valid;
  logic signed [SAMPLE_W-1:0] max_valid;
  logic [MARGIN_W-1:0]        disc_margin;
  logic [TOL_W-1:0]           stuck_tol;
  logic [THRESH_W-1:0]        unstable_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid    <= RST_MIN_VALID;
      max_valid    <= RST_MAX_VALID;
      disc_margin  <= RST_DISC_MARGIN;
      stuck_tol    <= RST_STUCK_TOL;
      unstable_thr <= RST_UNSTABLE_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_VALID:    min_valid    <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_MAX_VALID:    max_valid    <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_DISC_MARGIN:  disc_margin  <= cfg_data[MARGIN_W-1:0];
        CFG_STUCK_TOL:    stuck_tol    <= cfg_data[TOL_W-1:0];
        CFG_UNSTABLE_THR: unstable_thr <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat and range checks
  logic                       accept;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W+1:0] lo_bound;
  logic signed [SAMPLE_W+1:0] hi_bound;
  logic signed [SAMPLE_W+1:0] sample_x;
  logic                       is_invalid;
  logic                       is_disc;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign sample   = $signed(s_tdata[SAMPLE_W-1:0]);
  assign sample_x = (SAMPLE_W + 2)'(sample);
  assign lo_bound = (SAMPLE_W + 2)'(min_valid) + $signed({3'b000, disc_margin});
  assign hi_bound = (SAMPLE_W + 2)'(max_valid) - $signed({3'b000, disc_margin});
  assign is_invalid = (sample < min_valid) || (sample > max_valid);
  assign is_disc    = (sample_x <= lo_bound) || (sample_x >= hi_bound);

  // ring pointer and fill count
  logic [AW-1:0]    write_slot;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_next;

  assign fill_next = (fill_count == CNT_W'(N)) ? fill_count : fill_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept) begin
      write_slot <= (write_slot == AW'(N - 1)) ? '0 : write_slot + 1'b1;
      fill_count <= fill_next;
    end
  end

  // ring memory, one write or one read per cycle
  logic signed [SAMPLE_W-1:0] ring [N];
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       rd_en;

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= sample;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // sweep address issue and read-data tags
  logic          issue_done;
  logic          rd_vld;
  logic          rd_first;
  logic          rd_last;

  assign rd_en = (state == ST_SWEEP) && !issue_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      rd_first   <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_first <= rd_en && (rd_addr == '0);
      rd_last  <= rd_en && (rd_addr == AW'(N - 1));
      if (accept) begin
        rd_addr    <= '0;
        issue_done <= 1'b0;
      end else if (rd_en) begin
        if (rd_addr == AW'(N - 1)) begin
          issue_done <= 1'b1;
        end else begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
    end
  end

  // window accumulation: sum, sum of squares, deviation from slot zero
  logic signed [S1_W-1:0]     s1;
  logic [S2_W-1:0]            s2;
  logic signed [SAMPLE_W-1:0] ref_val;
  logic                       stuck;
  logic signed [2*SAMPLE_W-1:0] rd_sq;
  logic signed [SAMPLE_W:0]   dev;
  logic [SAMPLE_W:0]          dev_abs;

  assign rd_sq   = rd_data * rd_data;
  assign dev     = (SAMPLE_W + 1)'(rd_data) - (SAMPLE_W + 1)'(ref_val);
  assign dev_abs = dev[SAMPLE_W] ? (SAMPLE_W + 1)'(-dev) : (SAMPLE_W + 1)'(dev);

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (rd_first) begin
        s1      <= S1_W'(rd_data);
        s2      <= S2_W'(rd_sq[2*SAMPLE_W-2:0]);
        ref_val <= rd_data;
        stuck   <= 1'b1;
      end else begin
        s1 <= s1 + S1_W'(rd_data);
        s2 <= s2 + S2_W'(rd_sq[2*SAMPLE_W-2:0]);
        if (dev_abs > {1'b0, stuck_tol}) begin
          stuck <= 1'b0;
        end
      end
    end
  end

  // variance numerator N*S2 - S1^2
  logic [S1_W-1:0]  s1_abs;
  logic [NUM_W-1:0] s1_sq;
  logic [NUM_W-1:0] n_s2;
  logic [NUM_W-1:0] var_num;

  assign s1_abs = s1[S1_W-1] ? S1_W'(-s1) : S1_W'(s1);

  always_ff @(posedge clk) begin
    if (state == ST_SQUARE) begin
      s1_sq <= s1_abs * s1_abs;
      n_s2  <= NUM_W'(s2) << AW;
    end
    if (state == ST_DIFF) begin
      var_num <= n_s2 - s1_sq;
    end
  end

  // variance divide by N*N
  logic             div_start;
  logic             div_done;
  logic [VAR_W-1:0] variance;
  logic             div_busy_seen;

  assign div_start = (state == ST_DIV) && !div_busy_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy_seen <= 1'b0;
    end else if (state != ST_DIV) begin
      div_busy_seen <= 1'b0;
    end else begin
      div_busy_seen <= 1'b1;
    end
  end

  shm_divider #(
    .NUM_W (NUM_W),
    .SHIFT (2 * AW),
    .QUO_W (VAR_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (var_num),
    .done  (div_done),
    .quo   (variance)
  );

  // confidence scaling
  logic [PROD_W-1:0]         drop_prod;
  logic [PROD_W-VAR_FRAC-1:0] drop;

  assign drop = drop_prod[PROD_W-1:VAR_FRAC];

  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      drop_prod <= PROD_W'(variance) * PROD_W'(FULL_CONF);
    end
  end

  // pending result
  logic [HEALTH_W-1:0] res_health;
  logic [CONF_W-1:0]   res_conf;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_invalid) begin
        res_health <= HEALTH_INVALID;
        res_conf   <= ZERO_CONF;
      end else if (is_disc) begin
        res_health <= HEALTH_DISCONNECTED;
        res_conf   <= ZERO_CONF;
      end else begin
        res_health <= HEALTH_OK;
        res_conf   <= FULL_CONF;
      end
    end else if (state == ST_SQUARE && stuck) begin
      res_health <= HEALTH_STUCK;
      res_conf   <= STUCK_CONF;
    end else if (state == ST_SCALE) begin
      res_health <= (THRESH_W'(variance) > unstable_thr) ? HEALTH_UNSTABLE : HEALTH_OK;
    end else if (state == ST_CLAMP) begin
      res_conf <= (drop >= (PROD_W - VAR_FRAC)'(FULL_CONF))
                  ? ZERO_CONF : FULL_CONF - drop[CONF_W-1:0];
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_invalid || is_disc || fill_next != CNT_W'(N)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (rd_vld && rd_last) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: state <= stuck ? ST_DONE : ST_DIFF;
        ST_DIFF:   state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE:  state <= ST_CLAMP;
        ST_CLAMP:  state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // output register
  logic [HEALTH_W-1:0] out_health;
  logic [CONF_W-1:0]   out_conf;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_health <= res_health;
      out_conf   <= res_conf;
    end
  end

  assign m_tdata = {(M_TDATA_W - HEALTH_W - CONF_W)'(0), out_conf, out_health};

  // checks
  `SHM_ASSERT_IMP(a_depth_pow2, 1'b1, (N & (N - 1)) == 0,
                  "window depth is not a power of two")
  `SHM_ASSERT_NXT(a_accept_leaves_idle, accept, state != ST_IDLE,
                  "input beat taken but sequencer stayed idle")
  `SHM_ASSERT_IMP(a_fill_bound, 1'b1, fill_count <= CNT_W'(N),
                  "fill count beyond window depth")
  `SHM_ASSERT_IMP(a_stuck_conf, m_tvalid && out_health == HEALTH_STUCK,
                  out_conf == STUCK_CONF, "stuck result with wrong confidence")
  `SHM_ASSERT_IMP(a_reject_conf,
                  m_tvalid && (out_health == HEALTH_INVALID ||
                               out_health == HEALTH_DISCONNECTED),
                  out_conf == ZERO_CONF, "rejected sample with nonzero confidence")
  `SHM_ASSERT_IMP(a_div_in_div_state, div_done, state == ST_DIV,
                  "divider finished outside the divide state")

endmodule
